/* design/sorted_set_span_tracker_core_macros.svh */
`ifndef SORTED_SET_SPAN_TRACKER_CORE_MACROS_SVH
`define SORTED_SET_SPAN_TRACKER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SSST_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ssst check failed");

// next-cycle implication, sampled on clk, off during reset
`define SSST_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ssst check failed");

`endif

/* design/ssst_pkg.sv */
package ssst_pkg;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef struct packed {
		logic        has_pred;
		logic        has_succ;
		logic [31:0] pred;
		logic [31:0] succ;
	} nbr_t;

endpackage

/* design/ssst_queue.sv */
module ssst_queue #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop,
	output logic [W-1:0] pop_data
);

	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   fill_q;
	logic         do_push;
	logic         do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

/* design/ssst_cells.sv */
module ssst_cells #(
	parameter int N  = 64,
	parameter int CW = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         probe,
	output logic [N-1:0]        lt,
	output logic                hit,
	input  logic [N-1:0]        sel,
	input  logic                ins,
	input  logic [31:0]         ins_value,
	output ssst_pkg::nbr_t      nbr,
	output logic [CW-1:0]       count
);

	logic [31:0]   cell_q [N];
	logic [31:0]   prev   [N];
	logic [CW-1:0] count_q;
	logic [N-1:0]  vld;
	logic [N-1:0]  eq;
	logic [N-1:0]  sel_hi;
	logic [N-1:0]  sel_lo;
	logic [N-1:0]  pred_sel;
	logic [N-1:0]  succ_sel;

	assign count    = count_q;
	assign sel_hi   = {1'b0, sel[N-1:1]};
	assign sel_lo   = {sel[N-2:0], 1'b1};
	assign pred_sel = sel & ~sel_hi;
	assign succ_sel = ~sel & sel_lo & vld;
	assign hit      = |eq;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			vld[i] = (CW'(i) < count_q);
			lt[i]  = vld[i] && (cell_q[i] < probe);
			eq[i]  = vld[i] && (cell_q[i] == probe);
		end
	end

	always_comb begin
		nbr          = '0;
		nbr.has_pred = sel[0];
		nbr.has_succ = |succ_sel;
		for (int i = 0; i < N; i++) begin
			nbr.pred = nbr.pred | ({32{pred_sel[i]}} & cell_q[i]);
			nbr.succ = nbr.succ | ({32{succ_sel[i]}} & cell_q[i]);
		end
	end

	always_comb begin
		prev[0] = ins_value;
		for (int i = 1; i < N; i++) begin
			prev[i] = cell_q[i-1];
		end
	end

	// hold cells below the new value, drop it in at its place, shift the rest up
	always_ff @(posedge clk) begin
		if (ins) begin
			for (int i = 0; i < N; i++) begin
				if (!sel[i]) begin
					cell_q[i] <= sel_lo[i] ? ins_value : prev[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ins) begin
			count_q <= count_q + CW'(1);
		end
	end

endmodule

/* design/ssst_back.sv */
module ssst_back #(
	parameter int N  = 64,
	parameter int CW = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [6:0]          capacity,
	input  logic                q_valid,
	input  logic [31:0]         q_value,
	output logic                q_pop,
	output logic [31:0]         probe,
	input  logic [N-1:0]        lt,
	input  logic                hit,
	output logic [N-1:0]        sel,
	output logic                ins,
	output logic [31:0]         ins_value,
	input  ssst_pkg::nbr_t      nbr,
	input  logic [CW-1:0]       cell_count,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [6:0]          count,
	output logic                spans_valid,
	output logic [31:0]         shortest_span,
	output logic [31:0]         longest_span
);

	localparam logic [CW+6:0] LIM = (CW+7)'(N);

	logic                s1_v_q;
	logic [31:0]         v_s1;
	logic                s2_v_q;
	logic [31:0]         v_s2;
	logic [N-1:0]        lt_s2;
	ssst_pkg::status_t   st_s2;
	logic                s3_v_q;
	ssst_pkg::status_t   st_s3;
	logic [CW-1:0]       cnt_s3;
	logic [31:0]         gp_s3;
	logic [31:0]         gs_s3;
	logic                hp_s3;
	logic                hs_s3;
	logic [31:0]         span_s3;
	logic [31:0]         lo_q;
	logic [31:0]         hi_q;
	logic [31:0]         min_gap_q;
	logic                out_valid_q;

	logic                adv_s2;
	logic                adv_s3;
	logic                full;
	logic [CW+6:0]       cap_x;
	logic [CW+6:0]       lim_x;
	ssst_pkg::status_t   st_s1;
	logic                is_ins;
	logic [31:0]         lo_n;
	logic [31:0]         hi_n;
	logic [31:0]         m1;
	logic [31:0]         mg;
	logic                sv;
	logic [CW+6:0]       cnt_x;

	assign adv_s3    = s3_v_q && (!out_valid_q || out_ready);
	assign adv_s2    = s2_v_q && (!s3_v_q || adv_s3);
	assign q_pop     = q_valid && !s1_v_q && (!s2_v_q || adv_s2);
	assign probe     = v_s1;
	assign sel       = lt_s2;
	assign ins_value = v_s2;
	assign is_ins    = (st_s2 == ssst_pkg::ST_INSERTED);
	assign ins       = adv_s2 && is_ins;
	assign out_valid = out_valid_q;

	assign cap_x = {{CW{1'b0}}, capacity};
	assign lim_x = (cap_x > LIM) ? LIM : cap_x;
	assign full  = ({7'd0, cell_count} >= lim_x);

	always_comb begin
		if (full) begin
			st_s1 = ssst_pkg::ST_FULL;
		end else if (hit) begin
			st_s1 = ssst_pkg::ST_DUPLICATE;
		end else begin
			st_s1 = ssst_pkg::ST_INSERTED;
		end
	end

	assign lo_n = (is_ins && !nbr.has_pred) ? v_s2 : lo_q;
	assign hi_n = (is_ins && !nbr.has_succ) ? v_s2 : hi_q;

	assign m1    = (hp_s3 && (gp_s3 < min_gap_q)) ? gp_s3 : min_gap_q;
	assign mg    = (hs_s3 && (gs_s3 < m1)) ? gs_s3 : m1;
	assign sv    = (cnt_s3 >= CW'(2));
	assign cnt_x = {7'd0, cnt_s3};

	always_ff @(posedge clk) begin
		if (q_pop) begin
			v_s1 <= q_value;
		end
		if (s1_v_q) begin
			v_s2  <= v_s1;
			lt_s2 <= lt;
			st_s2 <= st_s1;
		end
		if (adv_s2) begin
			st_s3   <= st_s2;
			cnt_s3  <= cell_count + (is_ins ? CW'(1) : CW'(0));
			gp_s3   <= v_s2 - nbr.pred;
			gs_s3   <= nbr.succ - v_s2;
			hp_s3   <= is_ins && nbr.has_pred;
			hs_s3   <= is_ins && nbr.has_succ;
			span_s3 <= hi_n - lo_n;
			lo_q    <= lo_n;
			hi_q    <= hi_n;
		end
		if (adv_s3) begin
			status        <= st_s3;
			count         <= cnt_x[6:0];
			spans_valid   <= sv;
			shortest_span <= sv ? mg : 32'd0;
			longest_span  <= sv ? span_s3 : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q      <= 1'b0;
			s2_v_q      <= 1'b0;
			s3_v_q      <= 1'b0;
			out_valid_q <= 1'b0;
			min_gap_q   <= '1;
		end else begin
			if (q_pop) begin
				s1_v_q <= 1'b1;
			end else if (s1_v_q) begin
				s1_v_q <= 1'b0;
			end
			if (s1_v_q) begin
				s2_v_q <= 1'b1;
			end else if (adv_s2) begin
				s2_v_q <= 1'b0;
			end
			if (adv_s2) begin
				s3_v_q <= 1'b1;
			end else if (adv_s3) begin
				s3_v_q <= 1'b0;
			end
			if (adv_s3) begin
				out_valid_q <= 1'b1;
				min_gap_q   <= mg;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* design/sorted_set_span_tracker_core.sv */
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    value
// out      output     out_valid / out_ready  status, count, spans_valid,
//                                            shortest_span, longest_span
// cfg      input      cfg_we                 cfg_wdata (capacity)
//
// A transfer waits in the queue, then it is compared against every cell at once,
// the cell row is shifted and its gap is folded into the result register that
// drives out_valid. The compare stage takes no new item while it still holds one.
// Reset empties the set at once; no clearing pass. While out_ready is low the
// pipeline holds three items and the queue two more, then in_ready drops.
module sorted_set_span_tracker_core #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [6:0]  count,
	output logic        spans_valid,
	output logic [31:0] shortest_span,
	output logic [31:0] longest_span
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);

	logic [6:0]            cap_q;
	logic                  q_valid;
	logic                  q_pop;
	logic [31:0]           q_value;
	logic [31:0]           probe;
	logic [MAX_ENTRIES-1:0] lt;
	logic                  hit;
	logic [MAX_ENTRIES-1:0] sel;
	logic                  ins;
	logic [31:0]           ins_value;
	ssst_pkg::nbr_t        nbr;
	logic [CW-1:0]         cell_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 7'd64;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	ssst_queue #(
		.W(32)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(in_valid),
		.push_ready(in_ready),
		.push_data (value),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_data  (q_value)
	);

	ssst_cells #(
		.N (MAX_ENTRIES),
		.CW(CW)
	) u_cells (
		.clk      (clk),
		.arst_n   (arst_n),
		.probe    (probe),
		.lt       (lt),
		.hit      (hit),
		.sel      (sel),
		.ins      (ins),
		.ins_value(ins_value),
		.nbr      (nbr),
		.count    (cell_count)
	);

	ssst_back #(
		.N (MAX_ENTRIES),
		.CW(CW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.capacity     (cap_q),
		.q_valid      (q_valid),
		.q_value      (q_value),
		.q_pop        (q_pop),
		.probe        (probe),
		.lt           (lt),
		.hit          (hit),
		.sel          (sel),
		.ins          (ins),
		.ins_value    (ins_value),
		.nbr          (nbr),
		.cell_count   (cell_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.count        (count),
		.spans_valid  (spans_valid),
		.shortest_span(shortest_span),
		.longest_span (longest_span)
	);

endmodule

/* design/ssst_checker.sv */
`include "sorted_set_span_tracker_core_macros.svh"

module ssst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [6:0]  count,
	input logic        spans_valid,
	input logic [31:0] shortest_span,
	input logic [31:0] longest_span
);

	`SSST_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(longest_span))
	`SSST_ASSERT_IMP(a_spans_flag, out_valid, spans_valid == (count >= 7'd2))
	`SSST_ASSERT_IMP(a_spans_zero, out_valid && !spans_valid, shortest_span == 32'd0 && longest_span == 32'd0)
	`SSST_ASSERT_IMP(a_gap_in_span, out_valid && spans_valid, shortest_span <= longest_span && shortest_span != 32'd0)
	`SSST_ASSERT_IMP(a_ins_count, out_valid && status == ssst_pkg::ST_INSERTED, count != 7'd0)

endmodule

bind sorted_set_span_tracker_core ssst_checker u_ssst_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.count        (count),
	.spans_valid  (spans_valid),
	.shortest_span(shortest_span),
	.longest_span (longest_span)
);
